/* rtl/eia_pkg.sv */
package eia_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned ID_W     = 11;
  localparam int unsigned SIG_W    = 32;
  localparam int unsigned COMP_W   = 5;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned MAX_ENTITIES_DEF   = 1024;
  localparam int unsigned NUM_COMPONENTS_DEF = 32;

  localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SET   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;
  localparam logic [REQ_W-1:0] REQ_QUERY = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_WRITE,
    OP_SET,
    OP_CLEAR,
    OP_QUERY
  } op_e;

  typedef struct packed {
    op_e              op;
    logic             id_ok;
    logic [ID_W-1:0]  id;
    logic [SIG_W-1:0] operand;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } bk_status_t;

endpackage

/* rtl/eia_front.sv */
module eia_front #(
  parameter int unsigned MAX_ENTITIES   = eia_pkg::MAX_ENTITIES_DEF,
  parameter int unsigned NUM_COMPONENTS = eia_pkg::NUM_COMPONENTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [eia_pkg::REQ_W-1:0]    req_type_i,
  input  logic [eia_pkg::ID_W-1:0]     entity_id_i,
  input  logic [eia_pkg::SIG_W-1:0]    signature_in_i,
  input  logic [eia_pkg::COMP_W-1:0]   component_index_i,
  input  eia_pkg::bk_status_t          bk_status_i,
  output eia_pkg::cmd_t                head_o,
  output logic                         head_valid_o
);
  import eia_pkg::*;

  localparam logic [SIG_W-1:0] SigMask = (NUM_COMPONENTS >= 32) ? {SIG_W{1'b1}} :
      SIG_W'((64'd1 << NUM_COMPONENTS) - 64'd1);

  cmd_t       q_mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  cmd_t       cmd;
  logic [SIG_W-1:0] bit_mask;

  assign busy         = bk_status_i.clearing | (cnt_q == 2'd2);
  assign push         = start & ~busy;
  assign head_o       = q_mem[rd_ptr_q];
  assign head_valid_o = (cnt_q != 2'd0);

  always_comb begin
    if (32'(component_index_i) < 32'(NUM_COMPONENTS)) begin
      bit_mask = SIG_W'(1) << component_index_i;
    end else begin
      bit_mask = '0;
    end
    cmd.id      = entity_id_i;
    cmd.id_ok   = (entity_id_i != '0) && (32'(entity_id_i) <= 32'(MAX_ENTITIES));
    cmd.operand = bit_mask;
    case (req_type_i)
      REQ_ALLOC: cmd.op = OP_ALLOC;
      REQ_FREE:  cmd.op = OP_FREE;
      REQ_WRITE: begin
        cmd.op      = OP_WRITE;
        cmd.operand = signature_in_i & SigMask;
      end
      REQ_SET:   cmd.op = OP_SET;
      REQ_CLEAR: cmd.op = OP_CLEAR;
      REQ_QUERY: cmd.op = OP_QUERY;
      default:   cmd.op = OP_QUERY;
    endcase
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (bk_status_i.pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push, bk_status_i.pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* rtl/eia_back.sv */
module eia_back #(
  parameter int unsigned MAX_ENTITIES = eia_pkg::MAX_ENTITIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  eia_pkg::cmd_t                 head_i,
  input  logic                          head_valid_i,
  output eia_pkg::bk_status_t           bk_status_o,
  output logic                          done_o,
  output logic [eia_pkg::STATUS_W-1:0]  status_o,
  output logic [eia_pkg::ID_W-1:0]      entity_id_out_o,
  output logic [eia_pkg::SIG_W-1:0]     signature_out_o,
  output logic                          exists_o
);
  import eia_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ENTITIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTITIES + 1);

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic             live_mem [MAX_ENTITIES];
  logic [SIG_W-1:0] sig_mem  [MAX_ENTITIES];
  logic [CNT_W-1:0] stk_mem  [MAX_ENTITIES];

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] clr_idx_q, clr_idx_d;
  logic [CNT_W-1:0] ctr_q, ctr_d;
  logic [CNT_W-1:0] stk_cnt_q, stk_cnt_d;
  cmd_t             cmd_q;

  logic             pop;
  logic [31:0]      head_m1;
  logic [IDX_W-1:0] rd_slot;
  logic [CNT_W-1:0] stk_top;
  logic [IDX_W-1:0] stk_ra;

  logic             live_rd_q;
  logic [SIG_W-1:0] sig_rd_q;
  logic [CNT_W-1:0] stk_rd_q;

  logic             live_we, live_wd;
  logic [IDX_W-1:0] live_wa;
  logic             sig_we;
  logic [IDX_W-1:0] sig_wa;
  logic [SIG_W-1:0] sig_wd;
  logic             stk_we;
  logic [IDX_W-1:0] stk_wa;
  logic [CNT_W-1:0] stk_wd;

  logic [31:0]      cmd_m1;
  logic [IDX_W-1:0] cmd_slot;
  logic             live_x;
  logic             from_stk;
  logic             alloc_ok;
  logic [CNT_W-1:0] nid;
  logic [CNT_W-1:0] nid_m1;
  logic [SIG_W-1:0] new_sig;

  logic                done_d;
  logic [STATUS_W-1:0] res_status_d;
  logic [ID_W-1:0]     res_id_d;
  logic [SIG_W-1:0]    res_sig_d;
  logic                res_exists_d;

  assign pop                  = (state_q == S_IDLE) && head_valid_i;
  assign bk_status_o.pop      = pop;
  assign bk_status_o.clearing = (state_q == S_CLR);

  assign head_m1 = 32'(head_i.id) - 32'd1;
  assign rd_slot = head_m1[IDX_W-1:0];
  assign stk_top = stk_cnt_q - CNT_W'(1);
  assign stk_ra  = (stk_cnt_q != '0) ? stk_top[IDX_W-1:0] : '0;

  assign cmd_m1   = 32'(cmd_q.id) - 32'd1;
  assign cmd_slot = cmd_m1[IDX_W-1:0];
  assign live_x   = cmd_q.id_ok & live_rd_q;
  assign from_stk = (stk_cnt_q != '0);
  assign alloc_ok = from_stk || (32'(ctr_q) < 32'(MAX_ENTITIES));
  assign nid      = from_stk ? stk_rd_q : (ctr_q + CNT_W'(1));
  assign nid_m1   = nid - CNT_W'(1);

  always_comb begin
    case (cmd_q.op)
      OP_WRITE: new_sig = cmd_q.operand;
      OP_SET:   new_sig = sig_rd_q | cmd_q.operand;
      OP_CLEAR: new_sig = sig_rd_q & ~cmd_q.operand;
      default:  new_sig = sig_rd_q;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    clr_idx_d    = clr_idx_q;
    ctr_d        = ctr_q;
    stk_cnt_d    = stk_cnt_q;
    live_we      = 1'b0;
    live_wa      = cmd_slot;
    live_wd      = 1'b0;
    sig_we       = 1'b0;
    sig_wa       = cmd_slot;
    sig_wd       = new_sig;
    stk_we       = 1'b0;
    stk_wa       = stk_cnt_q[IDX_W-1:0];
    stk_wd       = CNT_W'(cmd_q.id);
    done_d       = 1'b0;
    res_status_d = ST_UNKNOWN;
    res_id_d     = '0;
    res_sig_d    = '0;
    res_exists_d = 1'b0;
    case (state_q)
      S_CLR: begin
        live_we   = 1'b1;
        live_wa   = clr_idx_q;
        clr_idx_d = clr_idx_q + IDX_W'(1);
        if (clr_idx_q == IDX_W'(MAX_ENTITIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        if (cmd_q.op == OP_ALLOC) begin
          if (alloc_ok) begin
            live_we      = 1'b1;
            live_wa      = nid_m1[IDX_W-1:0];
            live_wd      = 1'b1;
            sig_we       = 1'b1;
            sig_wa       = nid_m1[IDX_W-1:0];
            sig_wd       = '0;
            res_status_d = ST_OK;
            res_id_d     = ID_W'(nid);
            res_exists_d = 1'b1;
            if (from_stk) begin
              stk_cnt_d = stk_cnt_q - CNT_W'(1);
            end else begin
              ctr_d = ctr_q + CNT_W'(1);
            end
          end else begin
            res_status_d = ST_FULL;
          end
        end else if (live_x) begin
          res_status_d = ST_OK;
          res_id_d     = cmd_q.id;
          if (cmd_q.op == OP_FREE) begin
            live_we = 1'b1;
            if (32'(stk_cnt_q) < 32'(MAX_ENTITIES)) begin
              stk_we    = 1'b1;
              stk_cnt_d = stk_cnt_q + CNT_W'(1);
            end
          end else begin
            sig_we       = 1'b1;
            res_sig_d    = new_sig;
            res_exists_d = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (live_we) begin
      live_mem[live_wa] <= live_wd;
    end
    live_rd_q <= live_mem[rd_slot];
  end

  always_ff @(posedge clk_i) begin
    if (sig_we) begin
      sig_mem[sig_wa] <= sig_wd;
    end
    sig_rd_q <= sig_mem[rd_slot];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rd_q <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q <= head_i;
    end
    status_o        <= res_status_d;
    entity_id_out_o <= res_id_d;
    signature_out_o <= res_sig_d;
    exists_o        <= res_exists_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_idx_q <= '0;
      ctr_q     <= '0;
      stk_cnt_q <= '0;
      done_o    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
      ctr_q     <= ctr_d;
      stk_cnt_q <= stk_cnt_d;
      done_o    <= done_d;
    end
  end

endmodule

/* rtl/entity_id_allocator_signature_table_top.sv */
// Channel   | Direction | Handshake             | Payload
// request   | in        | start high, busy low  | req_type_i, entity_id_i, signature_in_i,
//           |           |                       | component_index_i
// result    | out       | done_o for one cycle  | status_o, entity_id_out_o, signature_out_o,
//           |           |                       | exists_o
//
// With an empty queue, a result passes through the queue entry, the command and memory
// read registers, and the result registers before it appears on the ports. The execution
// unit reads its memories, then executes each request, and takes no new request from the
// queue while it executes; a two-entry queue holds requests meanwhile.
// After reset a clearing pass over all MAX_ENTITIES entries (1024 by default) of the
// live-bit memory runs, with busy high, before the first request is taken.
// Results cannot be stalled by the receiver; after the clearing pass, busy rises only
// while the queue is full.
module entity_id_allocator_signature_table_top #(
  parameter int unsigned MAX_ENTITIES   = eia_pkg::MAX_ENTITIES_DEF,
  parameter int unsigned NUM_COMPONENTS = eia_pkg::NUM_COMPONENTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [eia_pkg::REQ_W-1:0]     req_type_i,
  input  logic [eia_pkg::ID_W-1:0]      entity_id_i,
  input  logic [eia_pkg::SIG_W-1:0]     signature_in_i,
  input  logic [eia_pkg::COMP_W-1:0]    component_index_i,
  output logic                          done_o,
  output logic [eia_pkg::STATUS_W-1:0]  status_o,
  output logic [eia_pkg::ID_W-1:0]      entity_id_out_o,
  output logic [eia_pkg::SIG_W-1:0]     signature_out_o,
  output logic                          exists_o
);
  import eia_pkg::*;

  cmd_t       head;
  logic       head_valid;
  bk_status_t bk_status;

  eia_front #(
    .MAX_ENTITIES   (MAX_ENTITIES),
    .NUM_COMPONENTS (NUM_COMPONENTS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .req_type_i        (req_type_i),
    .entity_id_i       (entity_id_i),
    .signature_in_i    (signature_in_i),
    .component_index_i (component_index_i),
    .bk_status_i       (bk_status),
    .head_o            (head),
    .head_valid_o      (head_valid)
  );

  eia_back #(
    .MAX_ENTITIES (MAX_ENTITIES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .head_valid_i    (head_valid),
    .bk_status_o     (bk_status),
    .done_o          (done_o),
    .status_o        (status_o),
    .entity_id_out_o (entity_id_out_o),
    .signature_out_o (signature_out_o),
    .exists_o        (exists_o)
  );

endmodule

/* rtl/eia_checker.sv */
module eia_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          done_o,
  input logic [eia_pkg::STATUS_W-1:0]  status_o,
  input logic [eia_pkg::ID_W-1:0]      entity_id_out_o,
  input logic [eia_pkg::SIG_W-1:0]     signature_out_o,
  input logic                          exists_o
);
  import eia_pkg::*;

  // Every request passes through the idle and execute states, so results never follow each other directly.
  a_no_back_to_back_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("results on consecutive cycles");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_OK || status_o == ST_UNKNOWN || status_o == ST_FULL))
    else $error("undefined status code");

  a_failure_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |->
      (entity_id_out_o == '0 && signature_out_o == '0 && !exists_o))
    else $error("failed request returned nonzero payload");

  a_live_has_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && exists_o) |-> (status_o == ST_OK && entity_id_out_o != '0))
    else $error("live entity reported without an ID");

endmodule

bind entity_id_allocator_signature_table_top eia_checker u_eia_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .done_o          (done_o),
  .status_o        (status_o),
  .entity_id_out_o (entity_id_out_o),
  .signature_out_o (signature_out_o),
  .exists_o        (exists_o)
);

/* tb/sv/tb_entity_id_allocator_signature_table_top.sv */
module tb_entity_id_allocator_signature_table_top;
  import eia_pkg::*;

  localparam int unsigned ENT_MAX  = MAX_ENTITIES_DEF;
  localparam int unsigned COMP_MAX = NUM_COMPONENTS_DEF;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam logic [REQ_W-1:0] REQ_RSVD_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_B = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [SIG_W-1:0]    sig;
    logic                exists;
  } response_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [REQ_W-1:0]    req_type_i;
  logic [ID_W-1:0]     entity_id_i;
  logic [SIG_W-1:0]    signature_in_i;
  logic [COMP_W-1:0]   component_index_i;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [ID_W-1:0]     entity_id_out_o;
  logic [SIG_W-1:0]    signature_out_o;
  logic                exists_o;

  int unsigned id_counter;
  int unsigned free_ids[$];
  int unsigned live_ids[$];
  bit          live_map[1:ENT_MAX];
  logic [SIG_W-1:0] signatures[1:ENT_MAX];

  response_t pending_responses[$];
  response_t want_resp;
  int unsigned mismatch_count;
  int unsigned stall_cycles;
  bit idle_on;

  entity_id_allocator_signature_table_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .req_type_i        (req_type_i),
    .entity_id_i       (entity_id_i),
    .signature_in_i    (signature_in_i),
    .component_index_i (component_index_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .entity_id_out_o   (entity_id_out_o),
    .signature_out_o   (signature_out_o),
    .exists_o          (exists_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic response_t allocator_response(logic [REQ_W-1:0] req,
                                                   logic [ID_W-1:0] id,
                                                   logic [SIG_W-1:0] sig_in,
                                                   logic [COMP_W-1:0] comp);
    response_t resp;
    int unsigned nid;
    int hits[$];
    logic [SIG_W-1:0] mask;
    resp = '0;
    mask = (COMP_MAX >= SIG_W) ? '1 : SIG_W'((64'd1 << COMP_MAX) - 1);
    if (req == REQ_ALLOC) begin
      if (free_ids.size() > 0) begin
        nid = free_ids[free_ids.size() - 1];
        free_ids.delete(free_ids.size() - 1);
      end else if (id_counter < ENT_MAX) begin
        id_counter++;
        nid = id_counter;
      end else begin
        resp.status = ST_FULL;
        return resp;
      end
      live_map[nid] = 1'b1;
      signatures[nid] = '0;
      live_ids.insert(live_ids.size(), nid);
      resp.status = ST_OK;
      resp.id = ID_W'(nid);
      resp.exists = 1'b1;
      return resp;
    end
    if (id == 0 || id > ENT_MAX || !live_map[id]) begin
      resp.status = ST_UNKNOWN;
      return resp;
    end
    case (req)
      REQ_FREE: begin
        live_map[id] = 1'b0;
        if (free_ids.size() < ENT_MAX) free_ids.insert(free_ids.size(), id);
        hits = live_ids.find_first_index(x) with (x == id);
        if (hits.size() > 0) live_ids.delete(hits[0]);
        resp.status = ST_OK;
        resp.id = id;
        return resp;
      end
      REQ_WRITE: signatures[id] = sig_in & mask;
      REQ_SET: if (comp < COMP_MAX) signatures[id][comp] = 1'b1;
      REQ_CLEAR: if (comp < COMP_MAX) signatures[id][comp] = 1'b0;
      default: ;
    endcase
    resp.status = ST_OK;
    resp.id = id;
    resp.sig = signatures[id];
    resp.exists = 1'b1;
    return resp;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_responses.size() == 0) begin
        note_mismatch($sformatf("unexpected transfer: status %0d id %0d sig %h exists %0d",
                                status_o, entity_id_out_o, signature_out_o, exists_o));
      end else begin
        want_resp = pending_responses.pop_front();
        if (status_o !== want_resp.status || entity_id_out_o !== want_resp.id ||
            signature_out_o !== want_resp.sig || exists_o !== want_resp.exists) begin
          note_mismatch($sformatf({"result differs: expected status %0d id %0d sig %h ",
                                   "exists %0d, got status %0d id %0d sig %h exists %0d"},
                                  want_resp.status, want_resp.id, want_resp.sig,
                                  want_resp.exists, status_o, entity_id_out_o,
                                  signature_out_o, exists_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                              logic [SIG_W-1:0] sig, logic [COMP_W-1:0] comp);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    req_type_i <= req;
    entity_id_i <= id;
    signature_in_i <= sig;
    component_index_i <= comp;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_responses.insert(pending_responses.size(), allocator_response(req, id, sig, comp));
  endtask

  task automatic drain_responses();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ID_W-1:0] pick_live_id();
    return ID_W'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
  endfunction

  task automatic random_request(int unsigned alloc_pct);
    int unsigned roll;
    logic [REQ_W-1:0] req;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      send_request(REQ_W'($urandom_range(0, 7)), ID_W'($urandom_range(0, 2047)),
                   $urandom, COMP_W'($urandom_range(0, 31)));
    end else if (live_ids.size() == 0 || roll < 10 + alloc_pct) begin
      send_request(REQ_ALLOC, ID_W'($urandom_range(0, 2047)), $urandom,
                   COMP_W'($urandom_range(0, 31)));
    end else begin
      case ($urandom_range(0, 9))
        0, 1:    req = REQ_FREE;
        2, 3:    req = REQ_WRITE;
        4, 5:    req = REQ_SET;
        6, 7:    req = REQ_CLEAR;
        8:       req = REQ_QUERY;
        default: req = ($urandom_range(0, 1) == 0) ? REQ_RSVD_A : REQ_RSVD_B;
      endcase
      send_request(req, pick_live_id(), $urandom, COMP_W'($urandom_range(0, 31)));
    end
  endtask

  task automatic test_directed_basics();
    idle_on = 1'b0;
    send_request(REQ_ALLOC, '0, '0, '0);
    send_request(REQ_ALLOC, '1, '1, '1);
    send_request(REQ_ALLOC, '0, '0, '0);
    send_request(REQ_QUERY, 11'd1, '0, '0);
    send_request(REQ_WRITE, 11'd1, 32'hFFFF_FFFF, '0);
    send_request(REQ_CLEAR, 11'd1, '0, 5'd0);
    send_request(REQ_CLEAR, 11'd1, '0, 5'd31);
    send_request(REQ_WRITE, 11'd2, 32'h0000_0000, '1);
    send_request(REQ_SET, 11'd2, '0, 5'd0);
    send_request(REQ_SET, 11'd2, '0, 5'd31);
    send_request(REQ_WRITE, 11'd3, 32'hA5A5_5A5A, '0);
    send_request(REQ_RSVD_A, 11'd3, '1, '1);
    send_request(REQ_RSVD_B, 11'd3, '0, '0);
    idle_on = 1'b1;
    send_request(REQ_FREE, 11'd2, '0, '0);
    send_request(REQ_QUERY, 11'd2, '0, '0);
    send_request(REQ_FREE, 11'd2, '0, '0);
    send_request(REQ_ALLOC, '0, '0, '0);
    send_request(REQ_QUERY, 11'd0, '0, '0);
    send_request(REQ_QUERY, 11'd1024, '0, '0);
    send_request(REQ_WRITE, 11'd1025, '1, '0);
    send_request(REQ_SET, 11'd2047, '0, 5'd31);
    send_request(REQ_CLEAR, 11'd0, '0, 5'd0);
    send_request(REQ_FREE, 11'd3, '0, '0);
    send_request(REQ_FREE, 11'd1, '0, '0);
    send_request(REQ_ALLOC, '0, '0, '0);
    send_request(REQ_ALLOC, '0, '0, '0);
    drain_responses();
  endtask

  task automatic test_random_traffic(int unsigned count, int unsigned alloc_pct);
    repeat (count) begin
      if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
      random_request(alloc_pct);
    end
    drain_responses();
  endtask

  task automatic test_fill_table();
    while (free_ids.size() != 0 || id_counter < ENT_MAX) begin
      if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
      send_request(REQ_ALLOC, ID_W'($urandom_range(0, 2047)), $urandom,
                   COMP_W'($urandom_range(0, 31)));
    end
    repeat (3) send_request(REQ_ALLOC, '0, '0, '0);
    repeat (6) send_request(REQ_FREE, pick_live_id(), '0, '0);
    repeat (7) send_request(REQ_ALLOC, '0, '0, '0);
    send_request(REQ_WRITE, 11'd1024, 32'hFFFF_FFFF, '0);
    send_request(REQ_CLEAR, 11'd1024, '0, 5'd31);
    send_request(REQ_QUERY, 11'd1024, '0, '0);
    drain_responses();
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_type_i = '0;
    entity_id_i = '0;
    signature_in_i = '0;
    component_index_i = '0;
    id_counter = 0;
    mismatch_count = 0;
    stall_cycles = 0;
    idle_on = 1'b0;
    foreach (live_map[i]) live_map[i] = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_basics();
    test_random_traffic(400, 35);
    test_fill_table();
    test_random_traffic(450, 25);

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/eia_pkg.sv
rtl/eia_front.sv
rtl/eia_back.sv
rtl/entity_id_allocator_signature_table_top.sv
rtl/eia_checker.sv
tb/sv/tb_entity_id_allocator_signature_table_top.sv
